// File: src/toy_core_execute_with_hazard_stalls_unit_defines.svh
// Assertion macros used by the execute unit's top-level RTL file.
`ifndef TOY_CORE_EXECUTE_WITH_HAZARD_STALLS_UNIT_DEFINES_SVH
`define TOY_CORE_EXECUTE_WITH_HAZARD_STALLS_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on aclk, disabled during reset.
`define TCX_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tcx: same-cycle check failed");

// Next-cycle implication, clocked on aclk, disabled during reset.
`define TCX_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tcx: next-cycle check failed");

`endif

// File: src/tcx_pkg.sv
// Types, constants and helpers shared by the execute unit.
package tcx_pkg;

    localparam int NUM_REGS      = 32;
    localparam int REG_W         = $clog2(NUM_REGS);
    localparam int BANK_WORDS    = 1024;
    localparam int ADDR_W        = $clog2(BANK_WORDS);
    localparam int NUM_BANKS     = 4;
    localparam int BANK_W        = $clog2(NUM_BANKS);
    localparam int MEM_WORDS     = NUM_BANKS * BANK_WORDS;
    localparam int MEM_IDX_W     = BANK_W + ADDR_W;
    localparam int PROGRAM_DEPTH = 1024;
    localparam int PC_W          = $clog2(PROGRAM_DEPTH) + 1;
    localparam int DATA_W        = 32;
    localparam int LAT_W         = 8;
    localparam int S_TDATA_W     = 72;
    localparam int S_TUSER_W     = 4;
    localparam int M_TDATA_W     = 176;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 8;

    localparam logic [PC_W-1:0]   PC_LIMIT       = PC_W'(PROGRAM_DEPTH);
    localparam logic [DATA_W-1:0] BRANCH_PENALTY = 32'd2;
    localparam logic [DATA_W-1:0] FWD_READY      = 32'd2;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_ADDI = 4'd3,
        OP_LD   = 4'd4,
        OP_LDC2 = 4'd5,
        OP_LDC3 = 4'd6,
        OP_LDC4 = 4'd7,
        OP_SW   = 4'd8,
        OP_BNE  = 4'd9,
        OP_J    = 4'd10,
        OP_NOP  = 4'd11
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORWARDING = 3'd0,
        CFG_CORE_ID    = 3'd1,
        CFG_ADD_LAT    = 3'd2,
        CFG_SUB_LAT    = 3'd3,
        CFG_MUL_LAT    = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic              fwd;
        logic [BANK_W-1:0] core_id;
        logic [LAT_W-1:0]  add_lat;
        logic [LAT_W-1:0]  sub_lat;
        logic [LAT_W-1:0]  mul_lat;
    } cfg_t;

    typedef struct packed {
        op_t               op;
        logic [REG_W-1:0]  rd;
        logic [REG_W-1:0]  rs1;
        logic [REG_W-1:0]  rs2;
        logic [DATA_W-1:0] imm;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] target;
        logic              known;
    } instr_t;

    typedef struct packed {
        logic [PC_W-1:0]   pc;
        logic [DATA_W-1:0] cycle;
        logic [DATA_W-1:0] stalls;
        logic [DATA_W-1:0] done;
    } arch_t;

    typedef struct packed {
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] ready1;
        logic [DATA_W-1:0] ready2;
        logic              known1;
        logic              known2;
        logic [DATA_W-1:0] mem_data;
    } operand_t;

    typedef struct packed {
        arch_t                arch;
        logic                 rf_we;
        logic [REG_W-1:0]     rf_addr;
        logic [DATA_W-1:0]    rf_data;
        logic                 rdy_we;
        logic [REG_W-1:0]     rdy_addr;
        logic [DATA_W-1:0]    rdy_data;
        logic                 mem_we;
        logic [MEM_IDX_W-1:0] mem_idx;
        logic [DATA_W-1:0]    mem_data;
    } update_t;

    typedef struct packed {
        logic [PC_W-1:0]   next_pc;
        logic [DATA_W-1:0] raw;
        logic [DATA_W-1:0] issue;
        logic              taken;
        logic [DATA_W-1:0] cycle;
        logic [DATA_W-1:0] stalls;
        logic [DATA_W-1:0] executed;
    } result_t;

    // Bank used by a memory operation: own bank for LD/SW, fixed bank for cross loads.
    function automatic logic [BANK_W-1:0] mem_bank(input logic [3:0] op_code,
                                                   input logic [BANK_W-1:0] core);
        if (op_code == OP_LD || op_code == OP_SW) begin
            return core;
        end
        return op_code[BANK_W-1:0];
    endfunction

endpackage

// File: src/tcx_ram.sv
// Generic single-write, single-read RAM with registered, enabled read.
module tcx_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/tcx_exec.sv
// Execute logic: hazard timing, ALU, branch resolution and state updates.
module tcx_exec (
    input  tcx_pkg::instr_t   item,
    input  tcx_pkg::operand_t opnd,
    input  tcx_pkg::cfg_t     cfg,
    input  tcx_pkg::arch_t    arch,
    output tcx_pkg::update_t  upd,
    output tcx_pkg::result_t  res
);

    function automatic logic [tcx_pkg::DATA_W-1:0] hazard_wait(
        input logic                        known,
        input logic [tcx_pkg::DATA_W-1:0]  rdy,
        input logic [tcx_pkg::DATA_W-1:0]  cyc,
        input logic                        fwd
    );
        logic [tcx_pkg::DATA_W-1:0] d;
        d = rdy - cyc;
        if (!known || d == '0 || d[tcx_pkg::DATA_W-1]) begin
            return '0;
        end
        if (fwd) begin
            return d - 32'd1;
        end
        return d;
    endfunction

    logic [tcx_pkg::LAT_W-1:0]  lat;
    logic [tcx_pkg::DATA_W-1:0] lat_ext;
    logic [tcx_pkg::DATA_W-1:0] extra;
    logic                       use1;
    logic                       use2;
    logic                       has_dest;
    logic [tcx_pkg::DATA_W-1:0] w1;
    logic [tcx_pkg::DATA_W-1:0] w2;
    logic [tcx_pkg::DATA_W-1:0] raw;
    logic [tcx_pkg::DATA_W-1:0] issue;
    logic                       taken;
    logic                       halted;
    logic [tcx_pkg::DATA_W-1:0] prod;

    assign prod = opnd.a * opnd.b;

    always_comb begin
        case (item.op)
            tcx_pkg::OP_ADD: lat = cfg.add_lat;
            tcx_pkg::OP_SUB: lat = cfg.sub_lat;
            tcx_pkg::OP_MUL: lat = cfg.mul_lat;
            default:         lat = 8'd1;
        endcase
        lat_ext  = {24'd0, lat};
        use1     = item.op inside {tcx_pkg::OP_ADD, tcx_pkg::OP_SUB, tcx_pkg::OP_MUL,
                                   tcx_pkg::OP_BNE, tcx_pkg::OP_ADDI, tcx_pkg::OP_SW};
        use2     = item.op inside {tcx_pkg::OP_ADD, tcx_pkg::OP_SUB, tcx_pkg::OP_MUL,
                                   tcx_pkg::OP_BNE};
        has_dest = item.op inside {[tcx_pkg::OP_ADD:tcx_pkg::OP_LDC4]};
        halted   = arch.pc >= tcx_pkg::PC_LIMIT;

        w1  = use1 ? hazard_wait(opnd.known1, opnd.ready1, arch.cycle, cfg.fwd) : '0;
        w2  = use2 ? hazard_wait(opnd.known2, opnd.ready2, arch.cycle, cfg.fwd) : '0;
        raw = (w2 > w1) ? w2 : w1;
        issue = arch.cycle + raw;

        taken = item.known &&
                ((item.op == tcx_pkg::OP_BNE && opnd.a != opnd.b) || item.op == tcx_pkg::OP_J);

        // stall cycles added after issue
        if (taken) begin
            extra = tcx_pkg::BRANCH_PENALTY;
        end else if (cfg.fwd || lat <= 8'd1) begin
            extra = '0;
        end else begin
            extra = lat_ext - 32'd1;
        end

        upd.rf_we   = 1'b0;
        upd.rf_addr = item.rd;
        upd.rf_data = opnd.a + opnd.b;
        if (!halted && !taken) begin
            case (item.op)
                tcx_pkg::OP_ADD:  begin
                    upd.rf_we   = 1'b1;
                    upd.rf_data = opnd.a + opnd.b;
                end
                tcx_pkg::OP_SUB:  begin
                    upd.rf_we   = 1'b1;
                    upd.rf_data = opnd.a - opnd.b;
                end
                tcx_pkg::OP_MUL:  begin
                    upd.rf_we   = 1'b1;
                    upd.rf_data = prod;
                end
                tcx_pkg::OP_ADDI: begin
                    upd.rf_we   = 1'b1;
                    upd.rf_data = opnd.a + item.imm;
                end
                tcx_pkg::OP_LD:   begin
                    upd.rf_we   = 1'b1;
                    upd.rf_data = opnd.mem_data;
                end
                tcx_pkg::OP_LDC2, tcx_pkg::OP_LDC3, tcx_pkg::OP_LDC4: begin
                    upd.rf_we   = (cfg.core_id == '0);
                    upd.rf_data = opnd.mem_data;
                end
                default: upd.rf_we = 1'b0;
            endcase
        end

        upd.rdy_we   = !halted && has_dest;
        upd.rdy_addr = item.rd;
        upd.rdy_data = issue + (cfg.fwd ? tcx_pkg::FWD_READY : lat_ext);

        upd.mem_we   = !halted && item.op == tcx_pkg::OP_SW;
        upd.mem_idx  = {tcx_pkg::mem_bank(item.op, cfg.core_id), item.addr};
        upd.mem_data = opnd.a;

        if (halted) begin
            upd.arch = arch;
        end else begin
            upd.arch.pc     = taken ? {1'b0, item.target} : arch.pc + 11'd1;
            upd.arch.cycle  = issue + (taken ? tcx_pkg::BRANCH_PENALTY :
                                       (cfg.fwd ? 32'd1 : lat_ext));
            upd.arch.stalls = arch.stalls + raw + extra;
            upd.arch.done   = arch.done + 32'd1;
        end

        res.next_pc  = upd.arch.pc;
        res.raw      = halted ? '0 : raw;
        res.issue    = halted ? arch.cycle : issue;
        res.taken    = !halted && taken;
        res.cycle    = upd.arch.cycle;
        res.stalls   = upd.arch.stalls;
        res.executed = upd.arch.done;
    end

endmodule

// File: src/toy_core_execute_with_hazard_stalls_unit.sv
// Top level of the execute unit with hazard timing: ports, stage and result registers.
// One instruction per cycle is accepted and retired in steady state while m_tready is
// high. An accepted instruction waits in the operand register (register file, ready
// table and data bank read, with bypass from the instruction retiring in the same
// cycle) and moves on to the result register when it retires; the result register
// frees the input side while m_tready is low for one item. After reset a clearing
// pass writes zero to all 4096 data words, one a cycle, and s_tready stays low until
// the pass is done; configuration writes are taken at any time and should be made
// while the unit is idle.
`include "toy_core_execute_with_hazard_stalls_unit_defines.svh"

module toy_core_execute_with_hazard_stalls_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // dest_index, src1_index, src2_index, immediate, mem_address, branch_target,
    // target_known, zero pad
    input  logic [tcx_pkg::S_TDATA_W-1:0]     s_tdata,
    // operation
    input  logic [tcx_pkg::S_TUSER_W-1:0]     s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // next_pc, raw_stall_cycles, issue_at, branch_taken, cycle_count,
    // stall_count, executed_count, zero pad
    output logic [tcx_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tcx_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tcx_pkg::CFG_DATA_W-1:0]    cfg_data
);

    tcx_pkg::cfg_t     cfg_reg;
    tcx_pkg::arch_t    arch_reg;
    tcx_pkg::instr_t   in_item;
    tcx_pkg::instr_t   stage_reg;
    tcx_pkg::operand_t opnd;
    tcx_pkg::update_t  upd;
    tcx_pkg::result_t  res;

    logic                            stage_valid_reg;
    logic                            out_valid_reg;
    logic [tcx_pkg::M_TDATA_W-1:0]   out_data_reg;
    logic                            clear_active_reg;
    logic [tcx_pkg::MEM_IDX_W-1:0]   clear_addr_reg;
    logic [tcx_pkg::NUM_REGS-1:0]    rf_valid_reg;
    logic [tcx_pkg::NUM_REGS-1:0]    ready_known_reg;

    logic                            byp_a_reg;
    logic                            byp_b_reg;
    logic                            vld_a_reg;
    logic                            vld_b_reg;
    logic [tcx_pkg::DATA_W-1:0]      byp_a_data_reg;
    logic [tcx_pkg::DATA_W-1:0]      byp_b_data_reg;
    logic                            byp_r1_reg;
    logic                            byp_r2_reg;
    logic                            known_r1_reg;
    logic                            known_r2_reg;
    logic [tcx_pkg::DATA_W-1:0]      byp_r1_data_reg;
    logic [tcx_pkg::DATA_W-1:0]      byp_r2_data_reg;
    logic                            byp_m_reg;
    logic [tcx_pkg::DATA_W-1:0]      byp_m_data_reg;

    logic [tcx_pkg::DATA_W-1:0]      rf_q_a;
    logic [tcx_pkg::DATA_W-1:0]      rf_q_b;
    logic [tcx_pkg::DATA_W-1:0]      rdy_q_1;
    logic [tcx_pkg::DATA_W-1:0]      rdy_q_2;
    logic [tcx_pkg::DATA_W-1:0]      mem_q;

    logic                            accept;
    logic                            retire;
    logic                            out_blocked;
    logic                            rf_wr;
    logic                            rdy_wr;
    logic                            mem_wr;
    logic [tcx_pkg::MEM_IDX_W-1:0]   in_mem_idx;
    logic                            dmem_we;
    logic [tcx_pkg::MEM_IDX_W-1:0]   dmem_waddr;
    logic [tcx_pkg::DATA_W-1:0]      dmem_wdata;

    assign in_item.op     = tcx_pkg::op_t'(s_tuser);
    assign in_item.rd     = s_tdata[4:0];
    assign in_item.rs1    = s_tdata[9:5];
    assign in_item.rs2    = s_tdata[14:10];
    assign in_item.imm    = s_tdata[46:15];
    assign in_item.addr   = s_tdata[56:47];
    assign in_item.target = s_tdata[66:57];
    assign in_item.known  = s_tdata[67];

    assign retire      = stage_valid_reg && (!out_valid_reg || m_tready);
    assign out_blocked = stage_valid_reg && out_valid_reg && !m_tready;
    assign s_tready    = !clear_active_reg && (!stage_valid_reg || retire);
    assign accept      = s_tvalid && s_tready;
    assign cfg_ready   = 1'b1;
    assign m_tvalid    = out_valid_reg;
    assign m_tdata     = out_data_reg;

    assign rf_wr  = retire && upd.rf_we;
    assign rdy_wr = retire && upd.rdy_we;
    assign mem_wr = retire && upd.mem_we;

    assign in_mem_idx = {tcx_pkg::mem_bank(s_tuser, cfg_reg.core_id), in_item.addr};

    assign dmem_we    = clear_active_reg || mem_wr;
    assign dmem_waddr = clear_active_reg ? clear_addr_reg : upd.mem_idx;
    assign dmem_wdata = clear_active_reg ? '0 : upd.mem_data;

    tcx_ram #(.DEPTH(tcx_pkg::NUM_REGS), .WIDTH(tcx_pkg::DATA_W)) u_rf_a (
        .aclk(aclk), .we(rf_wr), .waddr(upd.rf_addr), .wdata(upd.rf_data),
        .re(accept), .raddr(in_item.rs1), .rdata(rf_q_a)
    );

    tcx_ram #(.DEPTH(tcx_pkg::NUM_REGS), .WIDTH(tcx_pkg::DATA_W)) u_rf_b (
        .aclk(aclk), .we(rf_wr), .waddr(upd.rf_addr), .wdata(upd.rf_data),
        .re(accept), .raddr(in_item.rs2), .rdata(rf_q_b)
    );

    tcx_ram #(.DEPTH(tcx_pkg::NUM_REGS), .WIDTH(tcx_pkg::DATA_W)) u_rdy_1 (
        .aclk(aclk), .we(rdy_wr), .waddr(upd.rdy_addr), .wdata(upd.rdy_data),
        .re(accept), .raddr(in_item.rs1), .rdata(rdy_q_1)
    );

    tcx_ram #(.DEPTH(tcx_pkg::NUM_REGS), .WIDTH(tcx_pkg::DATA_W)) u_rdy_2 (
        .aclk(aclk), .we(rdy_wr), .waddr(upd.rdy_addr), .wdata(upd.rdy_data),
        .re(accept), .raddr(in_item.rs2), .rdata(rdy_q_2)
    );

    tcx_ram #(.DEPTH(tcx_pkg::MEM_WORDS), .WIDTH(tcx_pkg::DATA_W)) u_dmem (
        .aclk(aclk), .we(dmem_we), .waddr(dmem_waddr), .wdata(dmem_wdata),
        .re(accept), .raddr(in_mem_idx), .rdata(mem_q)
    );

    // operands: bypass from the retiring instruction, unwritten register entries read as zero
    assign opnd.a        = byp_a_reg ? byp_a_data_reg : (vld_a_reg ? rf_q_a : '0);
    assign opnd.b        = byp_b_reg ? byp_b_data_reg : (vld_b_reg ? rf_q_b : '0);
    assign opnd.ready1   = byp_r1_reg ? byp_r1_data_reg : rdy_q_1;
    assign opnd.ready2   = byp_r2_reg ? byp_r2_data_reg : rdy_q_2;
    assign opnd.known1   = known_r1_reg;
    assign opnd.known2   = known_r2_reg;
    assign opnd.mem_data = byp_m_reg ? byp_m_data_reg : mem_q;

    tcx_exec u_exec (
        .item (stage_reg),
        .opnd (opnd),
        .cfg  (cfg_reg),
        .arch (arch_reg),
        .upd  (upd),
        .res  (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg          <= '{fwd: 1'b0, core_id: '0, add_lat: 8'd1,
                                  sub_lat: 8'd1, mul_lat: 8'd1};
            arch_reg         <= '0;
            stage_valid_reg  <= 1'b0;
            out_valid_reg    <= 1'b0;
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
            rf_valid_reg     <= '0;
            ready_known_reg  <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (tcx_pkg::cfg_idx_t'(cfg_index))
                    tcx_pkg::CFG_FORWARDING: cfg_reg.fwd     <= cfg_data[0];
                    tcx_pkg::CFG_CORE_ID:    cfg_reg.core_id <= cfg_data[1:0];
                    tcx_pkg::CFG_ADD_LAT:    cfg_reg.add_lat <= cfg_data;
                    tcx_pkg::CFG_SUB_LAT:    cfg_reg.sub_lat <= cfg_data;
                    tcx_pkg::CFG_MUL_LAT:    cfg_reg.mul_lat <= cfg_data;
                    default: ;
                endcase
            end

            if (clear_active_reg) begin
                clear_addr_reg <= clear_addr_reg + 12'd1;
                if (clear_addr_reg == tcx_pkg::MEM_IDX_W'(tcx_pkg::MEM_WORDS - 1)) begin
                    clear_active_reg <= 1'b0;
                end
            end

            if (accept) begin
                stage_valid_reg <= 1'b1;
            end else if (retire) begin
                stage_valid_reg <= 1'b0;
            end

            if (retire) begin
                out_valid_reg <= 1'b1;
                arch_reg      <= upd.arch;
                if (upd.rf_we) begin
                    rf_valid_reg[upd.rf_addr] <= 1'b1;
                end
                if (upd.rdy_we) begin
                    ready_known_reg[upd.rdy_addr] <= 1'b1;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            stage_reg       <= in_item;
            byp_a_reg       <= rf_wr && upd.rf_addr == in_item.rs1;
            byp_b_reg       <= rf_wr && upd.rf_addr == in_item.rs2;
            byp_a_data_reg  <= upd.rf_data;
            byp_b_data_reg  <= upd.rf_data;
            vld_a_reg       <= rf_valid_reg[in_item.rs1];
            vld_b_reg       <= rf_valid_reg[in_item.rs2];
            byp_r1_reg      <= rdy_wr && upd.rdy_addr == in_item.rs1;
            byp_r2_reg      <= rdy_wr && upd.rdy_addr == in_item.rs2;
            byp_r1_data_reg <= upd.rdy_data;
            byp_r2_data_reg <= upd.rdy_data;
            known_r1_reg    <= ready_known_reg[in_item.rs1] ||
                               (rdy_wr && upd.rdy_addr == in_item.rs1);
            known_r2_reg    <= ready_known_reg[in_item.rs2] ||
                               (rdy_wr && upd.rdy_addr == in_item.rs2);
            byp_m_reg       <= mem_wr && upd.mem_idx == in_mem_idx;
            byp_m_data_reg  <= upd.mem_data;
        end
        if (retire) begin
            out_data_reg <= {4'd0, res.executed, res.stalls, res.cycle, res.taken,
                             res.issue, res.raw, res.next_pc};
        end
    end

    `TCX_ASSERT_IMP(a_no_accept_in_clear, clear_active_reg, !s_tready)
    `TCX_ASSERT_NXT(a_clear_runs_once, !clear_active_reg, !clear_active_reg)
    `TCX_ASSERT_NXT(a_stage_held_on_stall, out_blocked, stage_valid_reg && out_valid_reg)
    `TCX_ASSERT_NXT(a_retire_fills_output, retire, out_valid_reg)
    `TCX_ASSERT_IMP(a_pc_in_range, stage_valid_reg, arch_reg.pc <= tcx_pkg::PC_LIMIT)

endmodule
